### hw/rtl/fpalu_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpalu_pkg;

    localparam int DATA_BITS = 32;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int WORD_BITS_DEF = 32;

    typedef enum logic [3:0] {
        OP_ADD     = 4'd0,
        OP_SUB     = 4'd1,
        OP_MUL     = 4'd2,
        OP_DIV     = 4'd3,
        OP_GT      = 4'd4,
        OP_LT      = 4'd5,
        OP_GE      = 4'd6,
        OP_LE      = 4'd7,
        OP_EQ      = 4'd8,
        OP_NE      = 4'd9,
        OP_MIN     = 4'd10,
        OP_MAX     = 4'd11,
        OP_INC     = 4'd12,
        OP_DEC     = 4'd13,
        OP_TOINT   = 4'd14,
        OP_FROMINT = 4'd15
    } t_opcode;

endpackage

### hw/rtl/fixed_point_alu_top.sv
// Pipelined signed fixed-point ALU with a one-bit-per-stage divider.
// Every opcode takes the same path of registers: the input register, stage 0, the divider
// stages and the output register. A new beat can enter every cycle unless the pipeline is
// held. The path length is set by the restoring divider, which retires one quotient bit per
// stage over WORD_BITS + FRACTION_BITS stages; the multiplier uses one stage. The whole
// pipeline advances together and holds while a finished beat waits at the output.
module fixed_point_alu_top #(
    parameter int FRACTION_BITS = fpalu_pkg::FRACTION_BITS_DEF,
    parameter int WORD_BITS     = fpalu_pkg::WORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [3:0]                          i_opcode,
    input  logic signed [fpalu_pkg::DATA_BITS-1:0] i_operand_a,
    input  logic signed [fpalu_pkg::DATA_BITS-1:0] i_operand_b,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [fpalu_pkg::DATA_BITS-1:0] o_result_value,
    output logic                                o_compare_true,
    output logic                                o_divide_by_zero
);
    import fpalu_pkg::*;

    localparam int W = WORD_BITS;
    localparam int F = FRACTION_BITS;
    localparam int Q = W + F;

    logic en;

    logic            r_in_vld;
    t_opcode         r_in_op;
    logic signed [W-1:0] r_in_a;
    logic signed [W-1:0] r_in_b;

    logic            r_vld  [0:Q];
    t_opcode         r_op   [0:Q];
    logic [W-1:0]    r_res  [0:Q];
    logic            r_cmp  [0:Q];
    logic            r_dz   [0:Q];
    logic            r_neg  [0:Q];
    logic [W-1:0]    r_rem  [0:Q];
    logic [Q-1:0]    r_num  [0:Q];
    logic [W-1:0]    r_den  [0:Q];
    logic signed [2*W-1:0] r_prod;

    logic [W-1:0]    n_res;
    logic            n_cmp;
    logic signed [2*W-1:0] n_prod;
    logic [W-1:0]    n_abs_a;
    logic [W-1:0]    n_abs_b;
    logic signed [2*W-1:0] n_prod_sh;
    logic [Q-1:0]    n_quo;
    logic [W-1:0]    n_div_res;

    logic            r_out_vld;
    logic [W-1:0]    r_out_res;
    logic            r_out_cmp;
    logic            r_out_dz;

    assign en      = !(r_out_vld && i_stall);
    assign o_stall = !en;

    assign n_prod  = r_in_a * r_in_b;
    assign n_abs_a = r_in_a[W-1] ? (~r_in_a + W'(1)) : r_in_a;
    assign n_abs_b = r_in_b[W-1] ? (~r_in_b + W'(1)) : r_in_b;

    always_comb begin
        n_res = '0;
        n_cmp = 1'b0;
        case (r_in_op)
            OP_ADD:     n_res = r_in_a + r_in_b;
            OP_SUB:     n_res = r_in_a - r_in_b;
            OP_GT:      n_cmp = r_in_a > r_in_b;
            OP_LT:      n_cmp = r_in_a < r_in_b;
            OP_GE:      n_cmp = r_in_a >= r_in_b;
            OP_LE:      n_cmp = r_in_a <= r_in_b;
            OP_EQ:      n_cmp = r_in_a == r_in_b;
            OP_NE:      n_cmp = r_in_a != r_in_b;
            OP_MIN:     n_res = (r_in_a < r_in_b) ? r_in_a : r_in_b;
            OP_MAX:     n_res = (r_in_a > r_in_b) ? r_in_a : r_in_b;
            OP_INC:     n_res = r_in_a + W'(1);
            OP_DEC:     n_res = r_in_a - W'(1);
            OP_TOINT:   n_res = r_in_a >>> F;
            OP_FROMINT: n_res = r_in_a << F;
            default:    n_res = '0;
        endcase
    end

    assign n_prod_sh = r_prod >>> F;
    assign n_quo     = r_neg[Q] ? (~r_num[Q] + Q'(1)) : r_num[Q];
    assign n_div_res = r_dz[Q] ? '0 : n_quo[W-1:0];

    always_ff @(posedge i_clk) begin
        logic [W:0] trial;
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= Q; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_in_vld  <= i_valid;
            r_in_op   <= t_opcode'(i_opcode);
            r_in_a    <= i_operand_a[W-1:0];
            r_in_b    <= i_operand_b[W-1:0];

            r_vld[0]  <= r_in_vld;
            r_op[0]   <= r_in_op;
            r_res[0]  <= n_res;
            r_cmp[0]  <= n_cmp;
            r_dz[0]   <= (r_in_op == OP_DIV) && (r_in_b == '0);
            r_neg[0]  <= r_in_a[W-1] ^ r_in_b[W-1];
            r_rem[0]  <= '0;
            r_num[0]  <= {n_abs_a, F'(0)};
            r_den[0]  <= n_abs_b;
            r_prod    <= n_prod;

            for (int k = 1; k <= Q; k++) begin
                trial = {r_rem[k-1], r_num[k-1][Q-1]};
                r_vld[k] <= r_vld[k-1];
                r_op[k]  <= r_op[k-1];
                r_cmp[k] <= r_cmp[k-1];
                r_dz[k]  <= r_dz[k-1];
                r_neg[k] <= r_neg[k-1];
                r_den[k] <= r_den[k-1];
                if (k == 1 && r_op[0] == OP_MUL) begin
                    r_res[k] <= n_prod_sh[W-1:0];
                end else begin
                    r_res[k] <= r_res[k-1];
                end
                if (trial >= {1'b0, r_den[k-1]}) begin
                    r_rem[k] <= W'(trial - {1'b0, r_den[k-1]});
                    r_num[k] <= {r_num[k-1][Q-2:0], 1'b1};
                end else begin
                    r_rem[k] <= trial[W-1:0];
                    r_num[k] <= {r_num[k-1][Q-2:0], 1'b0};
                end
            end

            r_out_vld <= r_vld[Q];
            r_out_res <= (r_op[Q] == OP_DIV) ? n_div_res : r_res[Q];
            r_out_cmp <= r_cmp[Q];
            r_out_dz  <= r_dz[Q];
        end
    end

    assign o_valid          = r_out_vld;
    assign o_result_value   = DATA_BITS'($signed(r_out_res));
    assign o_compare_true   = r_out_cmp;
    assign o_divide_by_zero = r_out_dz;

endmodule

### hw/rtl/fpalu_checker.sv
// Port-level assertions for the fixed-point ALU and their binding.
module fpalu_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_stall,
    input logic                                o_stall,
    input logic                                o_valid,
    input logic signed [fpalu_pkg::DATA_BITS-1:0] o_result_value,
    input logic                                o_compare_true,
    input logic                                o_divide_by_zero
);
    import fpalu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value)
            && $stable(o_compare_true) && $stable(o_divide_by_zero))
        else $error("Stalled output beat changed.");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_by_zero |-> o_result_value == '0 && !o_compare_true)
        else $error("Divide by zero beat carries a nonzero result.");

    a_cmp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_compare_true |-> o_result_value == '0)
        else $error("Compare beat carries a nonzero result.");

    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("Input stalled with no beat waiting at the output.");

endmodule

bind fixed_point_alu_top fpalu_checker u_fpalu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_stall          (i_stall),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .o_result_value   (o_result_value),
    .o_compare_true   (o_compare_true),
    .o_divide_by_zero (o_divide_by_zero)
);
